@@ design/led_frame_deframer_gamma_unit_defines.svh @@
// Assertion macros shared by the LED frame deframer modules.
// Expects signals named clk and rst_n in the module that uses a macro.
`ifndef LED_FRAME_DEFRAMER_GAMMA_UNIT_DEFINES_SVH
`define LED_FRAME_DEFRAMER_GAMMA_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define LFDG_ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lfdg: property violated");
// Condition that must never be true at a clock edge outside reset.
`define LFDG_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lfdg: forbidden condition seen");
`else
`define LFDG_ASSERT_CLK(lbl, prop)
`define LFDG_ASSERT_NEVER(lbl, expr)
`endif

`endif

@@ design/lfdg_pkg.sv @@
// Shared types, constants and the gamma table of the LED frame deframer.
// No dependencies; the parser, read stage and top level refer to it by scoped names.
`default_nettype none

package lfdg_pkg;

    // Default sizes of the stores, the holdback delay and the second board's offset.
    localparam int BILLBOARD_BYTES_DEF = 300;
    localparam int SLIDER_BYTES_DEF    = 96;
    localparam int HOLDBACK_DEF        = 9;
    localparam int SECOND_OFFSET_DEF   = 150;

    // Field and internal widths.
    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 9;
    localparam int VALUE_W  = 18;
    localparam int COUNT_W  = 10;
    localparam int ADDR_W   = 11;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_STREAM         = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ_BILLBOARD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_SLIDER    = 2'd2;

    // Stream framing bytes.
    localparam logic [BYTE_W-1:0] FRAME_END = 8'hE0;
    localparam logic [BYTE_W-1:0] ESCAPE    = 8'hD0;

    // Board numbers that carry data.
    localparam logic [BYTE_W-1:0] BOARD_FIRST  = 8'd0;
    localparam logic [BYTE_W-1:0] BOARD_SECOND = 8'd1;
    localparam logic [BYTE_W-1:0] BOARD_SLIDER = 8'd2;

    // Payload counter saturates here.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

    // Gamma exponent as a ratio: 2.2 = 11 / 5.
    localparam int GAMMA_NUM   = 11;
    localparam int GAMMA_DEN   = 5;
    localparam int GAMMA_DEPTH = 256;

    typedef logic [VALUE_W-1:0] gamma_table_t [GAMMA_DEPTH];

    // Store write request from the parser.
    typedef struct packed {
        logic              bb_we;
        logic              sl_we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } wr_req_t;

    // Read issued into the response pipeline.
    typedef struct packed {
        logic valid;
        logic slider;
        logic oor;
    } rd_issue_t;

    // Builds the table at elaboration: entry v is the largest n with
    // n^5 <= v^11, found by a binary search on wide integers.
    function automatic gamma_table_t gamma_table_build();
        gamma_table_t tbl;
        logic [127:0] target;
        logic [127:0] probe;
        logic [VALUE_W:0] lo;
        logic [VALUE_W:0] hi;
        logic [VALUE_W:0] mid;
        for (int v = 0; v < GAMMA_DEPTH; v++) begin
            target = 128'd1;
            for (int e = 0; e < GAMMA_NUM; e++) begin
                target = target * 128'(v);
            end
            lo = '0;
            hi = {1'b0, {VALUE_W{1'b1}}};
            for (int k = 0; k <= VALUE_W + 1; k++) begin
                if (lo < hi) begin
                    mid = lo + ((hi - lo + 1'b1) >> 1);
                    probe = 128'd1;
                    for (int e = 0; e < GAMMA_DEN; e++) begin
                        probe = probe * 128'(mid);
                    end
                    if (probe <= target) begin
                        lo = mid;
                    end
                    else begin
                        hi = mid - 1'b1;
                    end
                end
            end
            tbl[v] = lo[VALUE_W-1:0];
        end
        return tbl;
    endfunction

    localparam gamma_table_t GAMMA_TABLE = gamma_table_build();

endpackage

`default_nettype wire

@@ design/lfdg_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module lfdg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/lfdg_parser.sv @@
// Stream byte parser: framing, escape handling, holdback delay, store writes.
// Depends on lfdg_pkg and the assertion macro header.
`default_nettype none
`include "led_frame_deframer_gamma_unit_defines.svh"

module lfdg_parser #(
    parameter int BILLBOARD_BYTES = lfdg_pkg::BILLBOARD_BYTES_DEF,
    parameter int SLIDER_BYTES    = lfdg_pkg::SLIDER_BYTES_DEF,
    parameter int HOLDBACK        = lfdg_pkg::HOLDBACK_DEF,
    parameter int SECOND_OFFSET   = lfdg_pkg::SECOND_OFFSET_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        byte_valid,
    input  wire logic [lfdg_pkg::BYTE_W-1:0] data_byte,
    output lfdg_pkg::wr_req_t                wr
);

    localparam int AW = lfdg_pkg::ADDR_W;
    localparam logic [AW-1:0] BB_LIMIT    = AW'(BILLBOARD_BYTES);
    localparam logic [AW-1:0] SL_LIMIT    = AW'(SLIDER_BYTES);
    localparam logic [AW-1:0] HOLD_LEN    = AW'(HOLDBACK);
    localparam logic [AW-1:0] SECOND_BASE = AW'(SECOND_OFFSET);

    typedef enum logic [2:0] {
        MODE_BOARD   = 3'b001,
        MODE_PAYLOAD = 3'b010,
        MODE_ESCAPED = 3'b100
    } mode_t;

    mode_t                         mode_reg;
    mode_t                         mode_next;
    logic [lfdg_pkg::BYTE_W-1:0]   board_reg;
    logic [lfdg_pkg::BYTE_W-1:0]   board_next;
    logic [lfdg_pkg::COUNT_W-1:0]  count_reg;
    logic [lfdg_pkg::COUNT_W-1:0]  count_next;

    logic                          push;
    logic [lfdg_pkg::BYTE_W-1:0]   push_byte;
    logic                          do_push;
    logic                          is_bb;
    logic                          is_sl;
    logic [lfdg_pkg::BYTE_W-1:0]   oldest;
    logic [AW-1:0]                 count_ext;
    logic [AW-1:0]                 bb_base;
    logic [AW-1:0]                 bb_addr;

    // Frame parsing: board byte, payload, escaped payload.
    always_comb
    begin
        mode_next  = mode_reg;
        board_next = board_reg;
        count_next = count_reg;
        push       = 1'b0;
        push_byte  = data_byte;
        if (byte_valid)
        begin
            case (mode_reg)
                MODE_BOARD:
                begin
                    board_next = data_byte;
                    count_next = '0;
                    mode_next  = MODE_PAYLOAD;
                end
                MODE_ESCAPED:
                begin
                    push      = 1'b1;
                    push_byte = data_byte + 8'd1;
                    mode_next = MODE_PAYLOAD;
                end
                MODE_PAYLOAD:
                begin
                    if (data_byte == lfdg_pkg::FRAME_END)
                    begin
                        mode_next = MODE_BOARD;
                    end
                    else if (data_byte == lfdg_pkg::ESCAPE)
                    begin
                        mode_next = MODE_ESCAPED;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_BOARD;
                end
            endcase
        end
        if (push && (count_reg != lfdg_pkg::COUNT_MAX))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign do_push = push && (count_reg != lfdg_pkg::COUNT_MAX);
    assign is_bb   = (board_reg == lfdg_pkg::BOARD_FIRST) ||
                     (board_reg == lfdg_pkg::BOARD_SECOND);
    assign is_sl   = (board_reg == lfdg_pkg::BOARD_SLIDER);

    // Holdback delay: billboard bytes leave the line HOLDBACK pushes later.
    generate
        if (HOLDBACK > 0)
        begin : g_hold
            logic [lfdg_pkg::BYTE_W-1:0] hold_reg  [HOLDBACK];
            logic [lfdg_pkg::BYTE_W-1:0] hold_next [HOLDBACK];

            always_comb
            begin
                hold_next[0] = push_byte;
                for (int i = 1; i < HOLDBACK; i++)
                begin
                    hold_next[i] = hold_reg[i-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (do_push && is_bb)
                begin
                    hold_reg <= hold_next;
                end
            end

            assign oldest = hold_reg[HOLDBACK-1];
        end
        else
        begin : g_no_hold
            assign oldest = push_byte;
        end
    endgenerate

    // Store write address and enables.
    assign count_ext = {1'b0, count_reg};
    assign bb_base   = (board_reg == lfdg_pkg::BOARD_SECOND) ? SECOND_BASE : '0;
    assign bb_addr   = bb_base + count_ext - HOLD_LEN;

    always_comb
    begin
        wr.bb_we = do_push && is_bb && (count_ext >= HOLD_LEN) &&
                   ((bb_base + count_ext) < (BB_LIMIT + HOLD_LEN));
        wr.sl_we = do_push && is_sl && (count_ext < SL_LIMIT);
        wr.addr  = is_sl ? count_ext : bb_addr;
        wr.data  = is_sl ? push_byte : oldest;
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BOARD;
            board_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            board_reg <= board_next;
            count_reg <= count_next;
        end
    end

    // Writes stay inside the stores and come only from their own boards.
    `LFDG_ASSERT_CLK(a_bb_addr_in_range, wr.bb_we |-> (wr.addr < BB_LIMIT))
    `LFDG_ASSERT_NEVER(a_single_store_write, wr.bb_we && wr.sl_we)
    `LFDG_ASSERT_CLK(a_slider_board, wr.sl_we |-> (board_reg == lfdg_pkg::BOARD_SLIDER))

endmodule

`default_nettype wire

@@ design/lfdg_read_stage.sv @@
// Read response pipeline: store data select, gamma lookup, output register.
// Depends on lfdg_pkg and the assertion macro header.
`default_nettype none
`include "led_frame_deframer_gamma_unit_defines.svh"

module lfdg_read_stage (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lfdg_pkg::rd_issue_t          issue,
    input  wire logic [lfdg_pkg::BYTE_W-1:0]  bb_rdata,
    input  wire logic [lfdg_pkg::BYTE_W-1:0]  sl_rdata,
    input  wire logic                         rsp_stall,
    output logic                              s1_free,
    output logic                              rsp_valid,
    output logic      [lfdg_pkg::VALUE_W-1:0] led_value,
    output logic                              out_of_range
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s1_slider_reg;
    logic                          s1_oor_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [lfdg_pkg::VALUE_W-1:0]  led_reg;
    logic [lfdg_pkg::VALUE_W-1:0]  led_next;
    logic                          oor_reg;
    logic                          out_adv;
    logic [lfdg_pkg::BYTE_W-1:0]   entry;

    // Handshake between the read stage and the output register.
    assign out_adv = !out_valid_reg || !rsp_stall;
    assign s1_free = !s1_valid_reg || out_adv;

    // Gamma lookup on the store data read when the request was issued.
    assign entry    = s1_slider_reg ? sl_rdata : bb_rdata;
    assign led_next = s1_oor_reg ? '0 : lfdg_pkg::GAMMA_TABLE[entry];

    always_comb
    begin
        s1_valid_next  = s1_valid_reg && !out_adv;
        if (issue.valid)
        begin
            s1_valid_next = 1'b1;
        end
        out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            s1_slider_reg <= issue.slider;
            s1_oor_reg    <= issue.oor;
        end
        if (out_adv && s1_valid_reg)
        begin
            led_reg <= led_next;
            oor_reg <= s1_oor_reg;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign led_value    = led_reg;
    assign out_of_range = oor_reg;

    // An issued read is held in the stage and moves on when the output frees.
    `LFDG_ASSERT_CLK(a_issue_lands, issue.valid |=> s1_valid_reg)
    `LFDG_ASSERT_CLK(a_stage_to_out, (s1_valid_reg && out_adv) |=> out_valid_reg)
    `LFDG_ASSERT_CLK(a_oor_zero, (rsp_valid && out_of_range) |-> (led_value == '0))

endmodule

`default_nettype wire

@@ design/led_frame_deframer_gamma_unit.sv @@
// Top level of the LED frame deframer with gamma corrected read-back.
// Depends on lfdg_pkg, lfdg_ram, lfdg_parser and lfdg_read_stage.
//
//   Channel   Direction  Handshake             Fields
//   req       in         req_valid / req_stall  cmd, data_byte, index
//   rsp       out        rsp_valid / rsp_stall  led_value, out_of_range
//
// One item is taken per cycle unless stalled; a stream byte writes its store when accepted.
// A read passes the store RAM read, then the gamma lookup into the output register on rsp.
// After reset a clearing pass zeroes both stores with req_stall high, walking
// the addresses up to the larger of BILLBOARD_BYTES and SLIDER_BYTES.
// After that, req_stall rises only when the read stage and the output register both
// hold an item and rsp_stall is high.
`default_nettype none

module led_frame_deframer_gamma_unit #(
    parameter int BILLBOARD_BYTES = lfdg_pkg::BILLBOARD_BYTES_DEF,
    parameter int SLIDER_BYTES    = lfdg_pkg::SLIDER_BYTES_DEF,
    parameter int HOLDBACK        = lfdg_pkg::HOLDBACK_DEF,
    parameter int SECOND_OFFSET   = lfdg_pkg::SECOND_OFFSET_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [lfdg_pkg::CMD_W-1:0]    cmd,
    input  wire logic [lfdg_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic [lfdg_pkg::INDEX_W-1:0]  index,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic      [lfdg_pkg::VALUE_W-1:0]  led_value,
    output logic                               out_of_range
);

    localparam int AW        = lfdg_pkg::ADDR_W;
    localparam int BB_AW     = (BILLBOARD_BYTES > 1) ? $clog2(BILLBOARD_BYTES) : 1;
    localparam int SL_AW     = (SLIDER_BYTES > 1) ? $clog2(SLIDER_BYTES) : 1;
    localparam int CLEAR_LEN = (BILLBOARD_BYTES > SLIDER_BYTES) ?
                               BILLBOARD_BYTES : SLIDER_BYTES;
    localparam int CLR_W     = $clog2(CLEAR_LEN);

    logic                          clearing_reg;
    logic                          clearing_next;
    logic [CLR_W-1:0]              clr_cnt_reg;
    logic [CLR_W-1:0]              clr_cnt_next;
    logic                          clr_bb_hit;
    logic                          clr_sl_hit;

    logic                          accept;
    logic                          byte_valid;
    logic [AW-1:0]                 idx_ext;
    logic                          rd_bb;
    logic                          rd_sl;
    logic                          bb_in;
    logic                          sl_in;
    logic                          s1_free;

    lfdg_pkg::wr_req_t             wr;
    lfdg_pkg::rd_issue_t           issue;

    logic                          bb_we;
    logic [BB_AW-1:0]              bb_waddr;
    logic [lfdg_pkg::BYTE_W-1:0]   bb_wdata;
    logic [lfdg_pkg::BYTE_W-1:0]   bb_rdata;
    logic                          sl_we;
    logic [SL_AW-1:0]              sl_waddr;
    logic [lfdg_pkg::BYTE_W-1:0]   sl_wdata;
    logic [lfdg_pkg::BYTE_W-1:0]   sl_rdata;

    // Input handshake.
    assign req_stall  = clearing_reg || !s1_free;
    assign accept     = req_valid && !req_stall;
    assign byte_valid = accept && (cmd == lfdg_pkg::CMD_STREAM);

    // Clearing pass after reset.
    assign clr_bb_hit = {1'b0, clr_cnt_reg} < (CLR_W + 1)'(BILLBOARD_BYTES);
    assign clr_sl_hit = {1'b0, clr_cnt_reg} < (CLR_W + 1)'(SLIDER_BYTES);

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            if (clr_cnt_reg == CLR_W'(CLEAR_LEN - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // Stream parser.
    lfdg_parser #(
        .BILLBOARD_BYTES (BILLBOARD_BYTES),
        .SLIDER_BYTES    (SLIDER_BYTES),
        .HOLDBACK        (HOLDBACK),
        .SECOND_OFFSET   (SECOND_OFFSET)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .data_byte  (data_byte),
        .wr         (wr)
    );

    // Store write ports: clearing pass or parser writes.
    always_comb
    begin
        if (clearing_reg)
        begin
            bb_we    = clr_bb_hit;
            bb_waddr = clr_cnt_reg[BB_AW-1:0];
            bb_wdata = '0;
            sl_we    = clr_sl_hit;
            sl_waddr = clr_cnt_reg[SL_AW-1:0];
            sl_wdata = '0;
        end
        else
        begin
            bb_we    = wr.bb_we;
            bb_waddr = wr.addr[BB_AW-1:0];
            bb_wdata = wr.data;
            sl_we    = wr.sl_we;
            sl_waddr = wr.addr[SL_AW-1:0];
            sl_wdata = wr.data;
        end
    end

    // Read decode: range check and RAM read enables.
    assign idx_ext = AW'(index);
    assign rd_bb   = accept && (cmd == lfdg_pkg::CMD_READ_BILLBOARD);
    assign rd_sl   = accept && (cmd == lfdg_pkg::CMD_READ_SLIDER);
    assign bb_in   = idx_ext < AW'(BILLBOARD_BYTES);
    assign sl_in   = idx_ext < AW'(SLIDER_BYTES);

    always_comb
    begin
        issue.valid  = rd_bb || rd_sl;
        issue.slider = rd_sl;
        issue.oor    = (rd_bb && !bb_in) || (rd_sl && !sl_in);
    end

    // Store memories.
    lfdg_ram #(
        .WIDTH (lfdg_pkg::BYTE_W),
        .DEPTH (BILLBOARD_BYTES),
        .AW    (BB_AW)
    ) u_bb_ram (
        .clk   (clk),
        .we    (bb_we),
        .waddr (bb_waddr),
        .wdata (bb_wdata),
        .re    (rd_bb && bb_in),
        .raddr (idx_ext[BB_AW-1:0]),
        .rdata (bb_rdata)
    );

    lfdg_ram #(
        .WIDTH (lfdg_pkg::BYTE_W),
        .DEPTH (SLIDER_BYTES),
        .AW    (SL_AW)
    ) u_sl_ram (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .re    (rd_sl && sl_in),
        .raddr (idx_ext[SL_AW-1:0]),
        .rdata (sl_rdata)
    );

    // Response pipeline.
    lfdg_read_stage u_read (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (issue),
        .bb_rdata     (bb_rdata),
        .sl_rdata     (sl_rdata),
        .rsp_stall    (rsp_stall),
        .s1_free      (s1_free),
        .rsp_valid    (rsp_valid),
        .led_value    (led_value),
        .out_of_range (out_of_range)
    );

endmodule

`default_nettype wire
